### design/indexed_config_regs_shadow_decode_defines.svh
// Assertion macros used by the checker file.
`ifndef INDEXED_CONFIG_REGS_SHADOW_DECODE_DEFINES_SVH
`define INDEXED_CONFIG_REGS_SHADOW_DECODE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ICRSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icrsd check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ICRSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icrsd check failed");

`endif

### design/icrsd_pkg.sv
// Shared types and constants for the index/data config register block.
package icrsd_pkg;

  localparam int unsigned RegCount = 13;
  localparam int unsigned EntryW   = 4;

  localparam logic [7:0] RegFirst = 8'h20;
  localparam logic [7:0] RegLast  = 8'h2C;
  localparam logic [7:0] IdleByte = 8'hFF;

  // access codes
  localparam logic OpRead    = 1'b0;
  localparam logic OpWrite   = 1'b1;
  localparam logic PortIndex = 1'b0;
  localparam logic PortData  = 1'b1;

  // register file entries used by the map decode (bus number - 0x20)
  localparam logic [EntryW-1:0] EntCache  = 4'd1;
  localparam logic [EntryW-1:0] EntShadow = 4'd2;
  localparam logic [EntryW-1:0] EntSegEn  = 4'd3;
  localparam logic [EntryW-1:0] EntCSeg   = 4'd6;

  typedef struct packed {
    logic       op;
    logic       port_sel;
    logic [7:0] wdata;
  } access_t;

  // post-access copies of the registers the decode looks at
  typedef struct packed {
    logic [7:0] cache;
    logic [7:0] shadow;
    logic [7:0] seg_en;
    logic [7:0] c_seg;
  } map_src_t;

  typedef struct packed {
    logic        bios_read_rom;
    logic        bios_write_blocked;
    logic [11:0] seg_read_internal;
    logic [11:0] seg_write_internal;
    logic [11:0] seg_write_blocked;
    logic        ext_cache_enable;
  } seg_map_t;

  function automatic logic [7:0] reg_reset_val(input logic [EntryW-1:0] ent);
    logic [7:0] v;
    case (ent)
      4'd0:    v = 8'h02;
      4'd1:    v = 8'h20;
      4'd2:    v = 8'hE4;
      4'd5:    v = 8'hF0;
      4'd6:    v = 8'h80;
      4'd7:    v = 8'hB1;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h10;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### design/icrsd_regs.sv
// Index register and 13-entry config register file with bus access logic.
module icrsd_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc_en,
  input  icrsd_pkg::access_t  acc,
  output logic [7:0]          rdata,
  output icrsd_pkg::map_src_t src
);

  logic [7:0] index_r;
  logic [7:0] index_nxt;
  logic [7:0] reg_file_r [icrsd_pkg::RegCount];

  logic                        idx_ok;
  logic [icrsd_pkg::EntryW-1:0] entry;
  logic                        file_wr;

  // 0x20..0x2C: the low nibble is the entry number
  assign idx_ok  = (index_r >= icrsd_pkg::RegFirst) && (index_r <= icrsd_pkg::RegLast);
  assign entry   = index_r[icrsd_pkg::EntryW-1:0];
  assign file_wr = acc_en && (acc.op == icrsd_pkg::OpWrite) &&
                   (acc.port_sel == icrsd_pkg::PortData) && idx_ok;

  always_comb begin
    index_nxt = index_r;
    if (acc_en && (acc.op == icrsd_pkg::OpWrite) && (acc.port_sel == icrsd_pkg::PortIndex)) begin
      index_nxt = acc.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= 8'h00;
    end else begin
      index_r <= index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < icrsd_pkg::RegCount; k++) begin
        reg_file_r[k] <= icrsd_pkg::reg_reset_val(icrsd_pkg::EntryW'(k));
      end
    end else if (file_wr) begin
      reg_file_r[entry] <= acc.wdata;
    end
  end

  always_comb begin
    rdata = icrsd_pkg::IdleByte;
    if ((acc.op == icrsd_pkg::OpRead) && (acc.port_sel == icrsd_pkg::PortData) && idx_ok) begin
      rdata = reg_file_r[entry];
    end
  end

  // map is decoded from the file as it stands after this word's write
  assign src.cache  = (file_wr && entry == icrsd_pkg::EntCache)  ? acc.wdata
                                                                 : reg_file_r[icrsd_pkg::EntCache];
  assign src.shadow = (file_wr && entry == icrsd_pkg::EntShadow) ? acc.wdata
                                                                 : reg_file_r[icrsd_pkg::EntShadow];
  assign src.seg_en = (file_wr && entry == icrsd_pkg::EntSegEn)  ? acc.wdata
                                                                 : reg_file_r[icrsd_pkg::EntSegEn];
  assign src.c_seg  = (file_wr && entry == icrsd_pkg::EntCSeg)   ? acc.wdata
                                                                 : reg_file_r[icrsd_pkg::EntCSeg];

endmodule

### design/icrsd_decode.sv
// Shadow RAM memory map decode from the config registers.
module icrsd_decode (
  input  icrsd_pkg::map_src_t src,
  output icrsd_pkg::seg_map_t map
);

  logic ext_wr;

  assign ext_wr = src.c_seg[6];

  always_comb begin
    logic on;
    logic prot;
    map = '0;
    map.bios_read_rom      = src.shadow[7];
    map.bios_write_blocked = !src.shadow[7];
    map.ext_cache_enable   = src.cache[4];
    // D and E segments: bits 0..3 use the D controls, 4..7 the E controls
    for (int i = 0; i < 8; i++) begin
      on   = ((i < 4) ? src.shadow[6] : src.shadow[5]) && src.seg_en[i];
      prot = (i < 4) ? src.shadow[4] : src.shadow[3];
      map.seg_read_internal[i]  = on;
      map.seg_write_blocked[i]  = (on || ext_wr) && prot;
      map.seg_write_internal[i] = (on || ext_wr) && !prot;
    end
    for (int i = 0; i < 4; i++) begin
      on   = src.c_seg[4] && src.c_seg[i];
      prot = src.c_seg[5];
      map.seg_read_internal[8+i]  = on;
      map.seg_write_blocked[8+i]  = (on || ext_wr) && prot;
      map.seg_write_internal[8+i] = (on || ext_wr) && !prot;
    end
  end

endmodule

### design/indexed_config_regs_shadow_decode.sv
// Top level: index/data config port with shadow RAM map decode.
//
// One bus word per clock cycle, sustained while out_stall is low. A word is
// held in an input register, then applied to the index register and register
// file once the output register is open; its result (read byte plus the memory
// map decoded from the registers after the access) lands in the output register
// at that same edge, and out_valid rises with it. The input register sits in
// front of the access logic and decode, and the output register behind them.
// in_stall rises only when the input register holds a word and the output
// register is full and stalled. Reset loads the register file defaults.
module indexed_config_regs_shadow_decode (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic        in_port_sel,
  input  logic [7:0]  in_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_bios_read_rom,
  output logic        out_bios_write_blocked,
  output logic [11:0] out_seg_read_internal,
  output logic [11:0] out_seg_write_internal,
  output logic [11:0] out_seg_write_blocked,
  output logic        out_ext_cache_enable
);

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  icrsd_pkg::access_t  s1_acc_r;
  icrsd_pkg::access_t  s1_acc_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [7:0]          rdata_r;
  logic [7:0]          rdata_nxt;
  icrsd_pkg::seg_map_t map_r;
  icrsd_pkg::seg_map_t map_nxt;

  logic                out_open;
  logic                advance;
  logic                accept;
  icrsd_pkg::map_src_t src;

  assign out_open = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_open;
  assign in_stall = s1_valid_r && !out_open;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt  = accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);
  assign s1_acc_nxt    = accept ? icrsd_pkg::access_t'{op: in_op, port_sel: in_port_sel,
                                                       wdata: in_wdata}
                                : s1_acc_r;

  icrsd_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_en (advance),
    .acc    (s1_acc_r),
    .rdata  (rdata_nxt),
    .src    (src)
  );

  icrsd_decode u_decode (
    .src (src),
    .map (map_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_acc_r <= s1_acc_nxt;
    if (advance) begin
      rdata_r <= rdata_nxt;
      map_r   <= map_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_read_data          = rdata_r;
  assign out_bios_read_rom      = map_r.bios_read_rom;
  assign out_bios_write_blocked = map_r.bios_write_blocked;
  assign out_seg_read_internal  = map_r.seg_read_internal;
  assign out_seg_write_internal = map_r.seg_write_internal;
  assign out_seg_write_blocked  = map_r.seg_write_blocked;
  assign out_ext_cache_enable   = map_r.ext_cache_enable;

endmodule

### design/icrsd_checker.sv
// Port-level checks for the config register block, bound to the top level.
`include "indexed_config_regs_shadow_decode_defines.svh"

module icrsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_data,
  input logic        out_bios_read_rom,
  input logic        out_bios_write_blocked,
  input logic [11:0] out_seg_read_internal,
  input logic [11:0] out_seg_write_internal,
  input logic [11:0] out_seg_write_blocked
);

  logic [19:0] out_watch;
  logic [11:0] rd_int_wr_ext;

  assign out_watch     = {out_read_data, out_seg_read_internal};
  assign rd_int_wr_ext = out_seg_read_internal &
                         ~(out_seg_write_internal | out_seg_write_blocked);

  // a stalled result word holds (read byte and read-internal segments checked)
  `ICRSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_watch))

  // input side only backs up behind a full output register
  `ICRSD_ASSERT_NOW(a_stall_cause, !out_valid, !in_stall)

  `ICRSD_ASSERT_NOW(a_bios_excl, out_valid, out_bios_write_blocked != out_bios_read_rom)

  `ICRSD_ASSERT_NOW(a_wr_excl, out_valid, (out_seg_write_internal & out_seg_write_blocked) == 12'h000)

  // an internally read segment never writes externally
  `ICRSD_ASSERT_NOW(a_rd_int_wr, out_valid, rd_int_wr_ext == 12'h000)

endmodule

bind indexed_config_regs_shadow_decode icrsd_checker u_icrsd_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_read_data          (out_read_data),
  .out_bios_read_rom      (out_bios_read_rom),
  .out_bios_write_blocked (out_bios_write_blocked),
  .out_seg_read_internal  (out_seg_read_internal),
  .out_seg_write_internal (out_seg_write_internal),
  .out_seg_write_blocked  (out_seg_write_blocked)
);
